@@ hw/rtl/wsd_pkg.sv @@
// shared types and constants for the websocket frame deframer
package wsd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 64;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned ExtCntW = 4;

  localparam logic [3:0] OPCODE_CLOSE = 4'h8;
  localparam logic [6:0] LEN_CODE_16  = 7'd126;
  localparam logic [6:0] LEN_CODE_64  = 7'd127;
  localparam logic [ExtCntW-1:0] EXT_BYTES_16 = 4'd2;
  localparam logic [ExtCntW-1:0] EXT_BYTES_64 = 4'd8;
  localparam logic [2:0] KEY_BYTES = 3'd4;
  localparam int unsigned MASK_BIT_POS = 7;

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXT     = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    kind_e            kind;
    logic             last;
    logic             unmasked_frame;
  } res_t;

endpackage

@@ hw/rtl/wsd_parser.sv @@
// frame header state machine and payload unmasking, one byte per accepted item
module wsd_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [wsd_pkg::ByteW-1:0] byte_i,
  output logic                     res_valid_o,
  output wsd_pkg::res_t            res_o
);

  wsd_pkg::phase_e                  phase_q, phase_d;
  logic [wsd_pkg::ExtCntW-1:0]      ext_left_q, ext_left_d;
  logic [wsd_pkg::LenW-1:0]         rem_len_q, rem_len_d;
  logic [wsd_pkg::KeyW-1:0]         mask_key_q, mask_key_d;
  logic [2:0]                       key_seen_q, key_seen_d;
  logic [1:0]                       key_idx_q, key_idx_d;
  logic                             close_q, close_d;
  logic                             unmasked_q, unmasked_d;

  logic [6:0]                       len7;
  logic [2:0]                       key_seen_inc;
  logic [wsd_pkg::LenW-1:0]         rem_dec;
  logic [wsd_pkg::ByteW-1:0]        key_byte;

  assign len7         = byte_i[6:0];
  assign key_seen_inc = key_seen_q + 3'd1;
  assign rem_dec      = rem_len_q - {{(wsd_pkg::LenW-1){1'b0}}, 1'b1};
  // key byte 0 is the first received, so it sits in the top byte
  assign key_byte     = mask_key_q[{~key_idx_q, 3'b000} +: 8];

  always_comb begin
    phase_d     = phase_q;
    ext_left_d  = ext_left_q;
    rem_len_d   = rem_len_q;
    mask_key_d  = mask_key_q;
    key_seen_d  = key_seen_q;
    key_idx_d   = key_idx_q;
    close_d     = close_q;
    unmasked_d  = unmasked_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      case (phase_q)
        wsd_pkg::PH_HDR0: begin
          close_d = (byte_i[3:0] == wsd_pkg::OPCODE_CLOSE);
          phase_d = wsd_pkg::PH_HDR1;
        end
        wsd_pkg::PH_HDR1: begin
          unmasked_d = ~byte_i[wsd_pkg::MASK_BIT_POS];
          mask_key_d = '0;
          key_seen_d = '0;
          key_idx_d  = '0;
          rem_len_d  = '0;
          if (len7 == wsd_pkg::LEN_CODE_16) begin
            ext_left_d = wsd_pkg::EXT_BYTES_16;
            phase_d    = wsd_pkg::PH_EXT;
          end else if (len7 == wsd_pkg::LEN_CODE_64) begin
            ext_left_d = wsd_pkg::EXT_BYTES_64;
            phase_d    = wsd_pkg::PH_EXT;
          end else begin
            ext_left_d = '0;
            rem_len_d  = {{(wsd_pkg::LenW-7){1'b0}}, len7};
            phase_d    = wsd_pkg::PH_MASK;
          end
          if (close_q) begin
            res_valid_o          = 1'b1;
            res_o.kind           = wsd_pkg::KIND_CLOSE;
            res_o.last           = 1'b1;
            res_o.unmasked_frame = ~byte_i[wsd_pkg::MASK_BIT_POS];
          end
        end
        wsd_pkg::PH_EXT: begin
          rem_len_d  = {rem_len_q[wsd_pkg::LenW-9:0], byte_i};
          ext_left_d = ext_left_q - 4'd1;
          if (ext_left_q == 4'd1) begin
            phase_d = wsd_pkg::PH_MASK;
          end
        end
        wsd_pkg::PH_MASK: begin
          mask_key_d = {mask_key_q[wsd_pkg::KeyW-9:0], byte_i};
          if (key_seen_inc < wsd_pkg::KEY_BYTES) begin
            key_seen_d = key_seen_inc;
          end else begin
            key_seen_d = '0;
            key_idx_d  = '0;
            if (rem_len_q != '0) begin
              phase_d = wsd_pkg::PH_PAYLOAD;
            end else begin
              phase_d = wsd_pkg::PH_HDR0;
              if (!close_q) begin
                res_valid_o          = 1'b1;
                res_o.kind           = wsd_pkg::KIND_EMPTY;
                res_o.last           = 1'b1;
                res_o.unmasked_frame = unmasked_q;
              end
            end
          end
        end
        wsd_pkg::PH_PAYLOAD: begin
          rem_len_d = rem_dec;
          key_idx_d = key_idx_q + 2'd1;
          if (rem_dec == '0) begin
            phase_d = wsd_pkg::PH_HDR0;
          end
          // a close frame's body is swallowed
          if (!close_q) begin
            res_valid_o          = 1'b1;
            res_o.payload_byte   = byte_i ^ key_byte;
            res_o.kind           = wsd_pkg::KIND_BYTE;
            res_o.last           = (rem_dec == '0);
            res_o.unmasked_frame = unmasked_q;
          end
        end
        default: begin
          close_d = (byte_i[3:0] == wsd_pkg::OPCODE_CLOSE);
          phase_d = wsd_pkg::PH_HDR1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= wsd_pkg::PH_HDR0;
      ext_left_q <= '0;
      rem_len_q  <= '0;
      mask_key_q <= '0;
      key_seen_q <= '0;
      key_idx_q  <= '0;
      close_q    <= 1'b0;
      unmasked_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      ext_left_q <= ext_left_d;
      rem_len_q  <= rem_len_d;
      mask_key_q <= mask_key_d;
      key_seen_q <= key_seen_d;
      key_idx_q  <= key_idx_d;
      close_q    <= close_d;
      unmasked_q <= unmasked_d;
    end
  end

  a_ctrl_result_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind != wsd_pkg::KIND_BYTE) |->
      res_o.last && (res_o.payload_byte == '0))
    else $error("empty or close result must be last and carry no byte");

  a_ext_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (phase_q == wsd_pkg::PH_EXT) |-> (ext_left_q != '0))
    else $error("extended length byte with no count left");

  a_payload_len_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (phase_q == wsd_pkg::PH_PAYLOAD) |-> (rem_len_q != '0))
    else $error("payload byte with zero length left");

  a_close_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && close_q && (phase_q != wsd_pkg::PH_HDR1) |-> 1'b0)
    else $error("close frame produced a result past its header");

endmodule

@@ hw/rtl/wsd_out_buf.sv @@
// result register with one skid entry so the input keeps flowing under stall
module wsd_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wsd_pkg::res_t res_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output wsd_pkg::res_t out_res_o
);

  logic          out_valid_q, out_valid_d;
  logic          skid_valid_q, skid_valid_d;
  wsd_pkg::res_t out_res_q, out_res_d;
  wsd_pkg::res_t skid_res_q, skid_res_d;
  logic          pop;

  assign pop         = out_valid_q & ~out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_res_d    = out_res_q;
    skid_res_d   = skid_res_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_res_d    = skid_res_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_res_d   = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_res_d   = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with the result register empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("result pushed while skid entry occupied");

  a_skid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_stall_i |=> skid_valid_q && $stable(skid_res_q))
    else $error("skid entry lost under stall");

endmodule

@@ hw/rtl/websocket_frame_deframer_top.sv @@
// websocket frame deframer top level: byte stream in, unmasked payload items out
// Takes one stream byte per clock while in_stall_o is low and, with at most one
// result per byte, places each result in the output register, or in the one-entry
// skid stage behind it when the output register holds a stalled result. That skid
// stage lets the input keep taking a byte per cycle while a result waits; in_stall_o
// rises only once that skid entry is occupied, i.e. after the consumer has held
// out_stall_i for a result and a second one has arrived. The frame parser works on
// each byte in the cycle it is taken (64-bit length decrement and compare set the path).
module websocket_frame_deframer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] stream_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic [1:0] kind_o,
  output logic       last_o,
  output logic       unmasked_frame_o
);

  logic          accept;
  logic          res_valid;
  logic          buf_full;
  wsd_pkg::res_t res;
  wsd_pkg::res_t out_res;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i & ~buf_full;

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (stream_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign payload_byte_o   = out_res.payload_byte;
  assign kind_o           = out_res.kind;
  assign last_o           = out_res.last;
  assign unmasked_frame_o = out_res.unmasked_frame;

endmodule

@@ tb/wsd_stream_checker.sv @@
// result checker for the websocket frame deframer: follows the frame layout and compares
module wsd_stream_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] stream_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] payload_byte_i,
  input  logic [1:0] kind_i,
  input  logic       last_i,
  input  logic       unmasked_frame_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  wsd_pkg::phase_e             rx_phase;
  logic [wsd_pkg::ExtCntW-1:0] ext_bytes_left;
  logic [wsd_pkg::LenW-1:0]    bytes_to_go;
  logic [wsd_pkg::KeyW-1:0]    key_word;
  logic [2:0]                  key_count;
  logic [1:0]                  key_pos;
  logic                        in_close_frame;
  logic                        frame_unmasked;

  wsd_pkg::res_t expected_results[$];

  initial fail_count_o = 0;

  task automatic note_result(input logic [7:0] data, input wsd_pkg::kind_e k,
                             input logic lst);
    wsd_pkg::res_t r;
    r.payload_byte   = data;
    r.kind           = k;
    r.last           = lst;
    r.unmasked_frame = frame_unmasked;
    expected_results.push_back(r);
  endtask

  task automatic decode_stream_byte(input logic [7:0] b);
    int         sh;
    logic [7:0] key_byte;
    case (rx_phase)
      wsd_pkg::PH_HDR1: begin
        frame_unmasked = !b[wsd_pkg::MASK_BIT_POS];
        key_word       = '0;
        key_count      = '0;
        key_pos        = '0;
        bytes_to_go    = '0;
        if (b[6:0] == wsd_pkg::LEN_CODE_16) begin
          ext_bytes_left = wsd_pkg::EXT_BYTES_16;
          rx_phase       = wsd_pkg::PH_EXT;
        end else if (b[6:0] == wsd_pkg::LEN_CODE_64) begin
          ext_bytes_left = wsd_pkg::EXT_BYTES_64;
          rx_phase       = wsd_pkg::PH_EXT;
        end else begin
          ext_bytes_left = '0;
          bytes_to_go    = wsd_pkg::LenW'(b[6:0]);
          rx_phase       = wsd_pkg::PH_MASK;
        end
        if (in_close_frame) note_result(8'h00, wsd_pkg::KIND_CLOSE, 1'b1);
      end
      wsd_pkg::PH_EXT: begin
        // length arrives most significant byte first
        bytes_to_go    = {bytes_to_go[wsd_pkg::LenW-9:0], b};
        ext_bytes_left = ext_bytes_left - 1'b1;
        if (ext_bytes_left == '0) rx_phase = wsd_pkg::PH_MASK;
      end
      wsd_pkg::PH_MASK: begin
        key_word  = {key_word[wsd_pkg::KeyW-9:0], b};
        key_count = key_count + 1'b1;
        if (key_count == wsd_pkg::KEY_BYTES) begin
          key_count = '0;
          key_pos   = '0;
          if (bytes_to_go != '0) begin
            rx_phase = wsd_pkg::PH_PAYLOAD;
          end else begin
            rx_phase = wsd_pkg::PH_HDR0;
            if (!in_close_frame) note_result(8'h00, wsd_pkg::KIND_EMPTY, 1'b1);
          end
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        // first key byte received sits in the top byte of the key word
        sh          = 24 - 8 * int'(key_pos);
        key_byte    = key_word[sh +: 8];
        bytes_to_go = bytes_to_go - 1'b1;
        key_pos     = key_pos + 1'b1;
        if (bytes_to_go == '0) rx_phase = wsd_pkg::PH_HDR0;
        if (!in_close_frame) begin
          note_result(b ^ key_byte, wsd_pkg::KIND_BYTE, bytes_to_go == '0);
        end
      end
      default: begin
        in_close_frame = (b[3:0] == wsd_pkg::OPCODE_CLOSE);
        rx_phase       = wsd_pkg::PH_HDR1;
      end
    endcase
  endtask

  task automatic check_result();
    wsd_pkg::res_t want;
    if (expected_results.size() == 0) begin
      $error("result with none expected: payload_byte %0h kind %0d last %0b unmasked_frame %0b",
             payload_byte_i, kind_i, last_i, unmasked_frame_i);
      fail_count_o++;
    end else begin
      want = expected_results.pop_front();
      if (payload_byte_i !== want.payload_byte) begin
        $error("payload_byte: expected %0h, got %0h", want.payload_byte, payload_byte_i);
        fail_count_o++;
      end
      if (kind_i !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, kind_i);
        fail_count_o++;
      end
      if (last_i !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last_i);
        fail_count_o++;
      end
      if (unmasked_frame_i !== want.unmasked_frame) begin
        $error("unmasked_frame: expected %0b, got %0b", want.unmasked_frame, unmasked_frame_i);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_phase       = wsd_pkg::PH_HDR0;
      ext_bytes_left = '0;
      bytes_to_go    = '0;
      key_word       = '0;
      key_count      = '0;
      key_pos        = '0;
      in_close_frame = 1'b0;
      frame_unmasked = 1'b0;
      expected_results.delete();
      pending_o      = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) decode_stream_byte(stream_byte_i);
      pending_o = expected_results.size();
    end
  end

endmodule

@@ tb/websocket_frame_deframer_top_test.sv @@
// testbench top for the websocket frame deframer: frame stimulus, flow control and verdict
module websocket_frame_deframer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] OPCODE_CONT     = 4'h0;
  localparam logic [3:0] OPCODE_TEXT     = 4'h1;
  localparam logic [3:0] OPCODE_BINARY   = 4'h2;
  localparam logic [3:0] OPCODE_RESERVED = 4'hF;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 20;
  localparam int HOLD_OFF_CYCLES  = 60;
  localparam int BYTES_PER_PHASE  = 170;
  localparam int RESET_CYCLES     = 7;

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] stream_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] payload_byte_o;
  logic [1:0] kind_o;
  logic       last_o;
  logic       unmasked_frame_o;

  int fail_count;
  int pending_count;

  logic [7:0] stream_q[$];
  int         in_idle_pct;
  int         out_idle_pct;
  bit         hold_off_req;
  int         hold_left;
  int         opcode_sweep;
  int         quiet_cycles;

  websocket_frame_deframer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .stream_byte_i   (stream_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .payload_byte_o  (payload_byte_o),
    .kind_o          (kind_o),
    .last_o          (last_o),
    .unmasked_frame_o(unmasked_frame_o)
  );

  wsd_stream_checker frame_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .stream_byte_i   (stream_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .payload_byte_i  (payload_byte_o),
    .kind_i          (kind_o),
    .last_i          (last_o),
    .unmasked_frame_i(unmasked_frame_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // receiver: random stalls, or one long hold-off when asked for
  initial begin
    out_stall_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_frame(input logic [3:0] opcode, input logic masked, input len_form_e form,
                           input logic [63:0] len, input logic [31:0] key,
                           input int unsigned payload_count);
    // fin and rsv bits are random, the block ignores them
    stream_q.push_back({4'($urandom_range(15)), opcode});
    case (form)
      LEN_SHORT: stream_q.push_back({masked, len[6:0]});
      LEN_EXT16: begin
        stream_q.push_back({masked, wsd_pkg::LEN_CODE_16});
        stream_q.push_back(len[15:8]);
        stream_q.push_back(len[7:0]);
      end
      default: begin
        stream_q.push_back({masked, wsd_pkg::LEN_CODE_64});
        for (int i = 7; i >= 0; i--) stream_q.push_back(len[8*i +: 8]);
      end
    endcase
    for (int i = 3; i >= 0; i--) stream_q.push_back(key[8*i +: 8]);
    for (int unsigned n = 0; n < payload_count; n++) stream_q.push_back(8'($urandom));
  endtask

  task automatic add_random_frame();
    logic [3:0]  opcode;
    logic        masked;
    len_form_e   form;
    int unsigned len;
    int unsigned pick;
    // the first frames walk through every opcode
    if (opcode_sweep < 16) begin
      opcode = 4'(opcode_sweep);
      opcode_sweep++;
    end else if ($urandom_range(99) < 15) begin
      opcode = wsd_pkg::OPCODE_CLOSE;
    end else begin
      opcode = 4'($urandom_range(15));
    end
    masked = ($urandom_range(99) >= 15);
    pick   = $urandom_range(99);
    if (pick < 70) begin
      form = LEN_SHORT;
      len  = ($urandom_range(9) == 0) ? $urandom_range(125) : $urandom_range(12);
    end else if (pick < 90) begin
      form = LEN_EXT16;
      len  = ($urandom_range(7) == 0) ? $urandom_range(300) : $urandom_range(20);
    end else begin
      form = LEN_EXT64;
      len  = $urandom_range(20);
    end
    add_frame(opcode, masked, form, 64'(len), $urandom, len);
  endtask

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic play_stream();
    while (stream_q.size() != 0) push_byte(stream_q.pop_front());
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    stream_byte_i = 8'h00;
    hold_off_req  = 1'b0;
    opcode_sweep  = 0;
    in_idle_pct   = 21;
    out_idle_pct  = 66;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // short frame with an all-zero key, then a close frame with payload that stays silent
    add_frame(OPCODE_TEXT, 1'b1, LEN_SHORT, 64'd3, 32'h0000_0000, 3);
    add_frame(wsd_pkg::OPCODE_CLOSE, 1'b1, LEN_SHORT, 64'd2, 32'hFFFF_FFFF, 2);
    // empty frame, unmasked close with no payload, unmasked empty via 16-bit length
    add_frame(OPCODE_BINARY, 1'b1, LEN_SHORT, 64'd0, 32'h1234_5678, 0);
    add_frame(wsd_pkg::OPCODE_CLOSE, 1'b0, LEN_SHORT, 64'd0, 32'hA5A5_5A5A, 0);
    add_frame(OPCODE_CONT, 1'b0, LEN_EXT16, 64'd0, 32'h0F0F_F0F0, 0);
    // reserved opcode read as data, 64-bit length
    add_frame(OPCODE_RESERVED, 1'b1, LEN_EXT64, 64'd2, 32'hFF00_FF00, 2);
    play_stream();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          in_idle_pct  = 21;
          out_idle_pct = 66;
        end
        1: begin
          in_idle_pct  = 66;
          out_idle_pct = 21;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
          // longest short frame, sent into a stalled receiver so the input backs up
          add_frame(OPCODE_BINARY, 1'b1, LEN_SHORT, 64'd125, $urandom, 125);
          hold_off_req = 1'b1;
        end
      endcase
      while (stream_q.size() < BYTES_PER_PHASE) add_random_frame();
      play_stream();
    end

    // length with the top bit set is taken as is; the frame simply never ends
    add_frame(OPCODE_BINARY, 1'b1, LEN_EXT64, 64'h8000_0000_0000_0005, $urandom, 40);
    play_stream();
    in_valid_i <= 1'b0;

    while (pending_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
